// ===== hw/rtl/lkvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvt_pkg: shared types for the linear key/value table
// Operation codes, payload widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lkvt_pkg;

  // Payload widths of the beats on both channels.
  localparam int unsigned FuncW  = 2;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Operation codes; the fourth code acts as a presence query.
  typedef enum logic [FuncW-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_ACT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/lkvt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvt_in_if / lkvt_out_if: request and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lkvt_in_if
  import lkvt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FuncW-1:0]         func;
  logic [KeyW-1:0]          key;
  logic signed [ValueW-1:0] new_value;

  modport source (output valid, func, key, new_value, input ready);
  modport sink   (input valid, func, key, new_value, output ready);
endinterface

interface lkvt_out_if
  import lkvt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] read_value;
  logic                     found;
  logic                     full_drop;
  logic [CountW-1:0]        entry_count;

  modport source (output valid, read_value, found, full_drop, entry_count, input ready);
  modport sink   (input valid, read_value, found, full_drop, entry_count, output ready);
endinterface

// ===== hw/rtl/linear_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_key_value_table: associative array with linear search
// Maps 8-bit keys to 32-bit signed values; insert, remove, lookup.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_bus.ready is high only while the
// sequencer is idle. The keys and values sit in a single-port-write,
// registered-read memory, and one compare unit walks the occupied entries
// from index 0, reading each entry examined and then comparing it. An empty
// table is not searched. A remove that hits an entry before the last
// occupied one shifts the later entries down, one memory read and one write
// per entry. The result sits in an output register, so the next request is
// taken while that beat still waits. No clearing pass runs after reset:
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module linear_key_value_table
  import lkvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lkvt_in_if.sink    in_bus,
  lkvt_out_if.source out_bus
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Table storage and registered read port.
  logic [KeyW-1:0]   key_mem_r [CAPACITY];
  logic [ValueW-1:0] val_mem_r [CAPACITY];
  logic [KeyW-1:0]   rd_key_r;
  logic [ValueW-1:0] rd_val_r;

  logic              mem_we;
  logic              key_we;
  logic [IW-1:0]     wr_addr;
  logic [KeyW-1:0]   wr_key;
  logic [ValueW-1:0] wr_val;
  logic [IW-1:0]     rd_addr;

  // Sequencer and request registers.
  state_t            state_r, state_nxt;
  func_t             func_r, func_nxt;
  logic [KeyW-1:0]   key_r, key_nxt;
  logic [ValueW-1:0] val_r, val_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic              hit_r, hit_nxt;
  logic              drop_r, drop_nxt;
  logic [ValueW-1:0] rdval_r, rdval_nxt;

  // Output register.
  logic              ovalid_r, ovalid_nxt;
  logic [ValueW-1:0] oval_r, oval_nxt;
  logic              ofound_r, ofound_nxt;
  logic              odrop_r, odrop_nxt;
  logic [CountW-1:0] ocount_r, ocount_nxt;

  logic              in_acc;
  logic              out_free;
  logic [CW:0]       idx_p1;
  logic [CW:0]       idx_p2;
  logic              more_scan;
  logic              more_shift;
  logic              match;

  assign in_bus.ready = state_r == ST_IDLE;
  assign in_acc     = in_bus.valid && in_bus.ready;
  assign out_free   = !ovalid_r || out_bus.ready;
  assign idx_p1     = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2     = {1'b0, idx_r} + (CW+1)'(2);
  assign more_scan  = idx_p1 < {1'b0, occ_r};
  assign more_shift = idx_p2 < {1'b0, occ_r};
  assign match      = rd_key_r == key_r;

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem_r[wr_addr] <= wr_val;
    end
    if (key_we) begin
      key_mem_r[wr_addr] <= wr_key;
    end
    rd_key_r <= key_mem_r[rd_addr];
    rd_val_r <= val_mem_r[rd_addr];
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (occ_r == '0) ? ST_ACT : ST_READ;
        end
      end
      ST_READ: state_nxt = ST_CMP;
      ST_CMP: begin
        if (match || !more_scan) begin
          state_nxt = ST_ACT;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_ACT: begin
        if (func_r == FN_REMOVE && hit_r && more_scan) begin
          state_nxt = ST_SHIFT_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT_RD: state_nxt = ST_SHIFT_WR;
      ST_SHIFT_WR: state_nxt = more_shift ? ST_SHIFT_RD : ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control for each state.
  always_comb begin
    func_nxt   = func_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    occ_nxt    = occ_r;
    hit_nxt    = hit_r;
    drop_nxt   = drop_r;
    rdval_nxt  = rdval_r;
    ovalid_nxt = ovalid_r && !out_bus.ready;
    oval_nxt   = oval_r;
    ofound_nxt = ofound_r;
    odrop_nxt  = odrop_r;
    ocount_nxt = ocount_r;
    mem_we     = 1'b0;
    key_we     = 1'b0;
    wr_addr    = idx_r[IW-1:0];
    wr_key     = key_r;
    wr_val     = val_r;
    rd_addr    = idx_r[IW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt  = func_t'(in_bus.func);
          key_nxt   = in_bus.key;
          val_nxt   = in_bus.new_value;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          drop_nxt  = 1'b0;
          rdval_nxt = '0;
        end
      end
      ST_READ: begin
        rd_addr = idx_r[IW-1:0];
      end
      // Compare the entry just read; advance, or stop on the first match or after the last occupied entry.
      ST_CMP: begin
        if (match) begin
          hit_nxt = 1'b1;
          if (func_r == FN_LOOKUP) begin
            rdval_nxt = rd_val_r;
          end
        end else if (more_scan) begin
          idx_nxt = idx_p1[CW-1:0];
        end
      end
      // Apply the operation once the search outcome is known.
      ST_ACT: begin
        case (func_r)
          FN_INSERT: begin
            if (hit_r) begin
              mem_we  = 1'b1;
              wr_addr = idx_r[IW-1:0];
            end else if (occ_r < CW'(CAPACITY)) begin
              mem_we  = 1'b1;
              key_we  = 1'b1;
              wr_addr = occ_r[IW-1:0];
              occ_nxt = occ_r + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end
          FN_REMOVE: begin
            if (hit_r && !more_scan) begin
              occ_nxt = occ_r - CW'(1);
            end
          end
          default: ;
        endcase
      end
      ST_SHIFT_RD: begin
        rd_addr = idx_p1[IW-1:0];
      end
      // Move the following entry down one place.
      ST_SHIFT_WR: begin
        mem_we  = 1'b1;
        key_we  = 1'b1;
        wr_addr = idx_r[IW-1:0];
        wr_key  = rd_key_r;
        wr_val  = rd_val_r;
        idx_nxt = idx_p1[CW-1:0];
        if (!more_shift) begin
          occ_nxt = occ_r - CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oval_nxt   = rdval_r;
          ofound_nxt = hit_r;
          odrop_nxt  = drop_r;
          ocount_nxt = CountW'(occ_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      occ_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      occ_r    <= occ_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    drop_r   <= drop_nxt;
    rdval_r  <= rdval_nxt;
    oval_r   <= oval_nxt;
    ofound_r <= ofound_nxt;
    odrop_r  <= odrop_nxt;
    ocount_r <= ocount_nxt;
  end

  assign out_bus.valid       = ovalid_r;
  assign out_bus.read_value  = oval_r;
  assign out_bus.found       = ofound_r;
  assign out_bus.full_drop   = odrop_r;
  assign out_bus.entry_count = ocount_r;

endmodule

// ===== hw/rtl/lkvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvt_checker: port-level checks for the key/value table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module lkvt_checker
  import lkvt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ValueW-1:0] out_read_value,
  input logic                     out_found,
  input logic                     out_full_drop,
  input logic [CountW-1:0]        out_entry_count
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // Only one request is in flight: the block is busy right after a beat.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // A miss or a dropped insert never returns a value.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_found || out_full_drop) |-> out_read_value == '0)
    else $error("value returned without a hit");

  // A drop happens only for an absent key on a full table.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_drop |->
      !out_found && out_entry_count == CountW'(CAPACITY))
    else $error("insert dropped while the table had room");

endmodule

bind linear_key_value_table lkvt_checker #(
  .CAPACITY(CAPACITY)
) u_lkvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_read_value  (out_bus.read_value),
  .out_found       (out_bus.found),
  .out_full_drop   (out_bus.full_drop),
  .out_entry_count (out_bus.entry_count)
);
